FILE: hw/rtl/overwrite_ring_fifo_with_pair_search_core_macros.svh
// ----------------------------------------------------------------------------
// overwrite ring fifo assertion macros
// shared concurrent assertion forms, sampled on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_FIFO_WITH_PAIR_SEARCH_CORE_MACROS_SVH
`define OVERWRITE_RING_FIFO_WITH_PAIR_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define ORFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ORFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/orfs_pkg.sv
// ----------------------------------------------------------------------------
// orfs_pkg
// types and constants of the overwrite ring fifo with pair search
// ----------------------------------------------------------------------------
`default_nettype none

package orfs_pkg;

	localparam int CAP_W  = 9;
	localparam int ADDR_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET    = 9'd256;
	localparam logic             REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		CMD_PUT    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  data_byte;
		logic [15:0] search_word;
	} item_t;

	typedef struct packed {
		logic [7:0]       read_byte;
		logic             read_valid;
		logic             overwrote;
		logic             found;
		logic [CAP_W-1:0] fill_count;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/orfs_ram.sv
// ----------------------------------------------------------------------------
// orfs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module orfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/overwrite_ring_fifo_with_pair_search_core.sv
// ----------------------------------------------------------------------------
// overwrite_ring_fifo_with_pair_search_core
// byte fifo in a circular store that overwrites the oldest byte when full,
// with a word search over the stored byte pairs
// ----------------------------------------------------------------------------
// An item is a transfer at a clock edge with start high and busy low. Every
// item gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so it must take the result in that cycle. Put and
// clear raise done in the cycle after the transfer and never raise busy.
// Get on a non-empty fifo raises busy for one cycle and done follows as
// busy falls (the registered read of the byte store); get on an empty fifo
// answers like put. Search walks the store one byte a cycle through the
// single read port: busy stays high while it walks the bytes below the fill
// count rounded down to even, and ends early on the first matching pair;
// done comes in the same cycle that busy falls. The capacity register (byte
// address 0) sets the slots in use, 0 acting as 1 and values above DEPTH as
// DEPTH; writing it also empties the fifo but keeps the stored bytes. Write
// it only while the block is idle. The store has no reset; a search only
// looks at positions below the fill count.
`default_nettype none

`include "overwrite_ring_fifo_with_pair_search_core_macros.svh"

module overwrite_ring_fifo_with_pair_search_core #(
	parameter int DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// item side
	input  wire logic                         start,
	output logic                              busy,
	input  wire orfs_pkg::item_t              item,
	// result side
	output logic                              done,
	output orfs_pkg::result_t                 result,
	// register port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [orfs_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = orfs_pkg::CAP_W;
	// compare width: holds DEPTH, the capacity and an index plus one
	localparam int CMPW = ((AW > CW) ? AW : CW) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GET,
		ST_SRCH
	} state_t;

	state_t            state_q;
	logic              done_q;
	orfs_pkg::result_t result_q;
	logic [CW-1:0]     cap_q;
	logic [AW-1:0]     wr_idx_q;
	logic [AW-1:0]     rd_idx_q;
	logic [CW-1:0]     held_q;
	logic [CMPW-1:0]   ptr_q;    // next search address to issue
	logic [CMPW-1:0]   lim_q;    // bytes covered by complete pairs
	logic              lo_hit_q; // low byte of the current pair matched
	logic [15:0]       word_q;

	logic              accept;
	logic              cfg_wr;
	logic [CMPW-1:0]   cap_eff;
	logic              full;
	logic [CMPW-1:0]   pair_lim;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;
	logic              ram_we;

	// wrap an index at the capacity in use
	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx,
		input logic [CMPW-1:0] cap);
		logic [CMPW-1:0] n;
		n = CMPW'(idx) + CMPW'(1);
		return (n >= cap) ? '0 : n[AW-1:0];
	endfunction

	assign accept   = start && !busy;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign result   = result_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == orfs_pkg::REG_CAPACITY) ? {23'd0, cap_q} : 32'd0;

	// clamp capacity to 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMPW'(1);
		end else if (CMPW'(cap_q) > CMPW'(DEPTH)) begin
			cap_eff = CMPW'(DEPTH);
		end else begin
			cap_eff = CMPW'(cap_q);
		end
	end

	assign full     = (CMPW'(held_q) >= cap_eff);
	// an odd trailing byte has no partner and is skipped
	assign pair_lim = CMPW'({held_q[CW-1:1], 1'b0});

	// one read port, shared by get and the search walk
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				rd_addr = (item.cmd == orfs_pkg::CMD_SEARCH) ? '0 : rd_idx_q;
			end
			ST_SRCH: begin
				rd_addr = ptr_q[AW-1:0];
			end
			default: begin
				rd_addr = rd_idx_q;
			end
		endcase
	end

	assign ram_we = accept && (item.cmd == orfs_pkg::CMD_PUT);

	orfs_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata (item.data_byte),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			cap_q    <= orfs_pkg::CAP_RESET;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			held_q   <= '0;
			ptr_q    <= '0;
			lim_q    <= '0;
			lo_hit_q <= 1'b0;
			word_q   <= '0;
		end else begin
			done_q <= 1'b0;

			// capacity write empties the fifo, bytes stay
			if (cfg_wr && (paddr[2] == orfs_pkg::REG_CAPACITY)) begin
				cap_q    <= pwdata[CW-1:0];
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				held_q   <= '0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.cmd)
							orfs_pkg::CMD_PUT: begin
								wr_idx_q <= step_idx(wr_idx_q, cap_eff);
								done_q   <= 1'b1;
								if (full) begin
									// drop the oldest byte
									rd_idx_q <= step_idx(rd_idx_q, cap_eff);
									result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
										overwrote: 1'b1, found: 1'b0, fill_count: held_q};
								end else begin
									held_q   <= held_q + CW'(1);
									result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
										overwrote: 1'b0, found: 1'b0,
										fill_count: held_q + CW'(1)};
								end
							end
							orfs_pkg::CMD_GET: begin
								if (held_q != '0) begin
									// byte comes back from the store next cycle
									rd_idx_q <= step_idx(rd_idx_q, cap_eff);
									held_q   <= held_q - CW'(1);
									state_q  <= ST_GET;
								end else begin
									done_q   <= 1'b1;
									result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
										overwrote: 1'b0, found: 1'b0, fill_count: held_q};
								end
							end
							orfs_pkg::CMD_SEARCH: begin
								word_q   <= item.search_word;
								lim_q    <= pair_lim;
								ptr_q    <= CMPW'(1);
								lo_hit_q <= 1'b0;
								if (pair_lim == '0) begin
									// nothing to compare
									done_q   <= 1'b1;
									result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
										overwrote: 1'b0, found: 1'b0, fill_count: held_q};
								end else begin
									state_q <= ST_SRCH;
								end
							end
							orfs_pkg::CMD_CLEAR: begin
								wr_idx_q <= '0;
								rd_idx_q <= '0;
								held_q   <= '0;
								done_q   <= 1'b1;
								result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
									overwrote: 1'b0, found: 1'b0, fill_count: '0};
							end
							default: begin
							end
						endcase
					end
				end
				ST_GET: begin
					done_q   <= 1'b1;
					result_q <= '{read_byte: rd_data, read_valid: 1'b1,
						overwrote: 1'b0, found: 1'b0, fill_count: held_q};
					state_q  <= ST_IDLE;
				end
				ST_SRCH: begin
					// rd_data holds the byte at ptr_q - 1
					if (!ptr_q[0] && lo_hit_q && (rd_data == word_q[15:8])) begin
						done_q   <= 1'b1;
						result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
							overwrote: 1'b0, found: 1'b1, fill_count: held_q};
						state_q  <= ST_IDLE;
					end else if (ptr_q == lim_q) begin
						// last pair checked, no match
						done_q   <= 1'b1;
						result_q <= '{read_byte: 8'd0, read_valid: 1'b0,
							overwrote: 1'b0, found: 1'b0, fill_count: held_q};
						state_q  <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + CMPW'(1);
						if (ptr_q[0]) begin
							lo_hit_q <= (rd_data == word_q[7:0]);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fill never runs past the slots in use
	`ORFS_ASSERT_IMP(a_held_in_cap, 1'b1, CMPW'(held_q) <= cap_eff, "fill count above capacity")
	// both pointers stay inside the slots in use
	`ORFS_ASSERT_IMP(a_idx_in_cap, 1'b1, (CMPW'(wr_idx_q) < cap_eff) && (CMPW'(rd_idx_q) < cap_eff), "index outside capacity")
	// the search walk never steps past the last complete pair
	`ORFS_ASSERT_IMP(a_walk_bound, state_q == ST_SRCH, (ptr_q != '0) && (ptr_q <= lim_q) && !lim_q[0], "search pointer out of range")
	// a result always leaves the block ready for the next item
	`ORFS_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result while still busy")
	// a non-empty get is answered in the cycle after its busy cycle
	`ORFS_ASSERT_NXT(a_get_done, state_q == ST_GET, done_q && result_q.read_valid, "get result missing")

endmodule

`default_nettype wire
